// ===== hw/rtl/gllg_pkg.sv =====
// Shared types, constants and helper functions of the load level governor.
// Depends on nothing; every other file of the block imports it.
package gllg_pkg;

    localparam int unsigned NUM_LEVELS      = 5;
    localparam int unsigned BUSY_CEILING_US = 50000;
    localparam int unsigned NUM_ENTRIES     = 5;

    localparam int unsigned LEVEL_W = 3;
    localparam int unsigned ACC_W   = 32;
    localparam int unsigned BUSY_W  = $clog2(BUSY_CEILING_US + 1);
    localparam int unsigned DIV_W   = $clog2(100 * BUSY_CEILING_US + 1);
    localparam int unsigned CNT_W   = $clog2(DIV_W);
    localparam int unsigned CMP_W   = DIV_W + 8;
    localparam int unsigned P_W     = 16;

    localparam logic [LEVEL_W:0] LVL_MAX = (LEVEL_W + 1)'(NUM_LEVELS - 1);

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_SLEEP  = 2'd1,
        OP_WAKE   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        OUT_WAIT  = 3'd0,
        OUT_EVAL  = 3'd1,
        OUT_FORCE = 3'd2,
        OUT_SLEEP = 3'd3,
        OUT_WAKE  = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DECIDE,
        ST_DIVIDE,
        ST_EVAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [23:0]        min_window_us;
        logic [6:0]         conservativeness_pct;
        logic [LEVEL_W-1:0] fastest_level;
        logic [LEVEL_W-1:0] slowest_level;
        logic [LEVEL_W-1:0] default_level;
        logic [39:0]        up_table;
        logic [39:0]        down_table;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic accum;
        logic decide;
        logic div_step;
        logic eval;
        logic out_write;
    } cmd_t;

    typedef struct packed {
        logic needs_div;
    } status_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               level_set;
        logic [7:0]         load_pct;
        outcome_t           outcome;
    } result_t;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lv);
        if ({1'b0, lv} > LVL_MAX) begin
            return LVL_MAX[LEVEL_W-1:0];
        end
        return lv;
    endfunction

    function automatic logic [7:0] table_entry(input logic [39:0] tbl,
                                               input logic [LEVEL_W-1:0] idx);
        if (idx >= LEVEL_W'(NUM_ENTRIES)) begin
            return 8'd0;
        end
        return tbl[{idx, 3'b000} +: 8];
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [23:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + (ACC_W + 1)'(b);
        if (s[ACC_W]) begin
            return '1;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/gpu_load_level_governor.sv =====
// Top level of the load level governor: register port, output stage, and
// the controller and datapath. Depends on gllg_pkg, gllg_ctrl and gllg_dp.
//
//  Channel  Direction  Beat contents
//  s_       in         tuser: operation; tdata: busy_us, total_us, in_nap
//  m_       out        tuser: outcome; tdata: level, level_set, load_pct
//  apb      in/out     register writes and reads, one register per 8 bytes
//
// One beat at a time. A sample that triggers an evaluation passes through the
// bit-serial divider that forms the load percentage; every other beat goes
// straight from the decision to the output stage.
// Reset is synchronous and clears the level, the accumulators and all
// handshake state. A stalled output holds its beat while the next input
// beat is already being worked on.
module gpu_load_level_governor
    import gllg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // busy_us[23:0], total_us[47:24], in_nap[48], zeros
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // level[2:0], level_set[3], load_pct[11:4], zeros
    output logic [2:0]  m_tuser,   // outcome[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [2:0] REG_MIN_WINDOW = 3'd0;
    localparam logic [2:0] REG_CONS_PCT   = 3'd1;
    localparam logic [2:0] REG_FASTEST    = 3'd2;
    localparam logic [2:0] REG_SLOWEST    = 3'd3;
    localparam logic [2:0] REG_DEFAULT    = 3'd4;
    localparam logic [2:0] REG_UP_TABLE   = 3'd5;
    localparam logic [2:0] REG_DOWN_TABLE = 3'd6;

    cfg_t    cfg_reg, cfg_next;
    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;
    cmd_t    cmd;
    status_t status;
    result_t result;
    logic    out_free;
    logic    wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_window_us        <= 24'd10000;
            cfg_reg.conservativeness_pct <= 7'd0;
            cfg_reg.fastest_level        <= 3'd0;
            cfg_reg.slowest_level        <= 3'd4;
            cfg_reg.default_level        <= 3'd0;
            cfg_reg.up_table             <= 40'h64_32_46_55_6E;
            cfg_reg.down_table           <= 40'h00_00_14_23_32;
            m_valid_reg                  <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_MIN_WINDOW: cfg_next.min_window_us        = pwdata[23:0];
                REG_CONS_PCT:   cfg_next.conservativeness_pct = pwdata[6:0];
                REG_FASTEST:    cfg_next.fastest_level        = pwdata[2:0];
                REG_SLOWEST:    cfg_next.slowest_level        = pwdata[2:0];
                REG_DEFAULT:    cfg_next.default_level        = pwdata[2:0];
                REG_UP_TABLE:   cfg_next.up_table             = pwdata[39:0];
                REG_DOWN_TABLE: cfg_next.down_table           = pwdata[39:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_WINDOW: prdata = 64'(cfg_reg.min_window_us);
            REG_CONS_PCT:   prdata = 64'(cfg_reg.conservativeness_pct);
            REG_FASTEST:    prdata = 64'(cfg_reg.fastest_level);
            REG_SLOWEST:    prdata = 64'(cfg_reg.slowest_level);
            REG_DEFAULT:    prdata = 64'(cfg_reg.default_level);
            REG_UP_TABLE:   prdata = 64'(cfg_reg.up_table);
            REG_DOWN_TABLE: prdata = 64'(cfg_reg.down_table);
            default:        prdata = 64'd0;
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (cmd.out_write) begin
            m_valid_next = 1'b1;
            m_res_next   = result;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    gllg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .out_free (out_free),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    gllg_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_op    (op_t'(s_tuser)),
        .in_busy  (s_tdata[23:0]),
        .in_total (s_tdata[47:24]),
        .in_nap   (s_tdata[48]),
        .status   (status),
        .result   (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_res_reg.load_pct, m_res_reg.level_set, m_res_reg.level};
    assign m_tuser  = m_res_reg.outcome;

endmodule

// ===== hw/rtl/gllg_ctrl.sv =====
// Controller state machine of the load level governor: sequences one beat.
// Depends on gllg_pkg; drives commands into gllg_dp.
module gllg_ctrl
    import gllg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    out_free,
    input  status_t status,
    output logic    s_tready,
    output cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                count_next = '0;
                state_next = status.needs_div ? ST_DIVIDE : ST_EMIT;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + 1'b1;
                if (count_reg == CNT_W'(DIV_W - 1)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/gllg_dp.sv =====
// Datapath of the load level governor: accumulators, level, serial divider.
// Depends on gllg_pkg; commanded by gllg_ctrl.
module gllg_dp
    import gllg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  cfg_t        cfg,
    input  op_t         in_op,
    input  logic [23:0] in_busy,
    input  logic [23:0] in_total,
    input  logic        in_nap,
    output status_t     status,
    output result_t     result
);

    op_t                op_reg, op_next;
    logic [23:0]        busy_in_reg, busy_in_next;
    logic [23:0]        total_in_reg, total_in_next;
    logic               nap_reg, nap_next;
    logic [ACC_W-1:0]   tot_acc_reg, tot_acc_next;
    logic [ACC_W-1:0]   busy_acc_reg, busy_acc_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [ACC_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [P_W-1:0]     p_up_reg, p_up_next;
    logic [P_W-1:0]     p_dn_reg, p_dn_next;
    logic               res_set_reg, res_set_next;
    logic [7:0]         res_load_reg, res_load_next;
    outcome_t           res_outcome_reg, res_outcome_next;

    logic               win;
    logic               force_fast;
    logic [ACC_W:0]     shifted;
    logic               ge;
    logic [P_W-1:0]     scale;
    logic [CMP_W-1:0]   scaled_load;
    logic               go_up;
    logic               go_dn;
    logic [LEVEL_W-1:0] lv_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_acc_reg  <= '0;
            busy_acc_reg <= '0;
            level_reg    <= '0;
        end else begin
            tot_acc_reg  <= tot_acc_next;
            busy_acc_reg <= busy_acc_next;
            level_reg    <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        busy_in_reg     <= busy_in_next;
        total_in_reg    <= total_in_next;
        nap_reg         <= nap_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        p_up_reg        <= p_up_next;
        p_dn_reg        <= p_dn_next;
        res_set_reg     <= res_set_next;
        res_load_reg    <= res_load_next;
        res_outcome_reg <= res_outcome_next;
    end

    assign win = (total_in_reg != 24'd0) &&
                 (tot_acc_reg >= ACC_W'(cfg.min_window_us));
    assign force_fast = (level_reg < cfg.fastest_level) || ({1'b0, level_reg} > LVL_MAX) ||
                        (busy_acc_reg > ACC_W'(BUSY_CEILING_US));
    assign status.needs_div = (op_reg == OP_SAMPLE) && win && !force_fast;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, tot_acc_reg};
    assign scale   = P_W'(8'(cfg.conservativeness_pct) + 8'd100);

    assign scaled_load = CMP_W'(quo_reg) * CMP_W'(100);
    assign go_up       = scaled_load > CMP_W'(p_up_reg);
    assign go_dn       = (scaled_load + CMP_W'(100)) <= CMP_W'(p_dn_reg);

    always_comb begin
        if (go_up) begin
            if ((level_reg == '0) || ((level_reg - 1'b1) < cfg.fastest_level)) begin
                lv_new = cfg.fastest_level;
            end else begin
                lv_new = level_reg - 1'b1;
            end
        end else if (go_dn) begin
            if (({1'b0, level_reg} + 1'b1) > {1'b0, cfg.slowest_level}) begin
                lv_new = cfg.slowest_level;
            end else begin
                lv_new = level_reg + 1'b1;
            end
        end else begin
            lv_new = level_reg;
        end
    end

    always_comb begin
        op_next          = op_reg;
        busy_in_next     = busy_in_reg;
        total_in_next    = total_in_reg;
        nap_next         = nap_reg;
        tot_acc_next     = tot_acc_reg;
        busy_acc_next    = busy_acc_reg;
        level_next       = level_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        p_up_next        = p_up_reg;
        p_dn_next        = p_dn_reg;
        res_set_next     = res_set_reg;
        res_load_next    = res_load_reg;
        res_outcome_next = res_outcome_reg;

        if (cmd.load) begin
            op_next       = in_op;
            busy_in_next  = in_busy;
            total_in_next = in_total;
            nap_next      = in_nap;
        end

        if (cmd.accum && (op_reg == OP_SAMPLE)) begin
            tot_acc_next  = sat_add(tot_acc_reg, total_in_reg);
            busy_acc_next = sat_add(busy_acc_reg, busy_in_reg);
        end

        if (cmd.decide) begin
            res_set_next     = 1'b0;
            res_load_next    = 8'd0;
            res_outcome_next = OUT_WAIT;
            rem_next         = '0;
            quo_next         = DIV_W'(busy_acc_reg[BUSY_W-1:0]) * DIV_W'(100);
            p_up_next        = P_W'(table_entry(cfg.up_table, level_reg)) * scale;
            p_dn_next        = P_W'(table_entry(cfg.down_table, level_reg)) * scale;
            case (op_reg)
                OP_SAMPLE: begin
                    if (win && force_fast) begin
                        level_next       = clamp_level(cfg.fastest_level);
                        res_set_next     = 1'b1;
                        res_outcome_next = OUT_FORCE;
                        tot_acc_next     = '0;
                        busy_acc_next    = '0;
                    end
                end
                OP_SLEEP: begin
                    level_next       = clamp_level(cfg.slowest_level);
                    res_set_next     = 1'b1;
                    res_outcome_next = OUT_SLEEP;
                    tot_acc_next     = '0;
                    busy_acc_next    = '0;
                end
                OP_WAKE: begin
                    if (!nap_reg) begin
                        level_next   = clamp_level(cfg.default_level);
                        res_set_next = 1'b1;
                    end
                    res_outcome_next = OUT_WAKE;
                end
                default: begin
                    res_outcome_next = OUT_WAIT;
                end
            endcase
        end

        if (cmd.div_step) begin
            if (ge) begin
                rem_next = ACC_W'(shifted - {1'b0, tot_acc_reg});
            end else begin
                rem_next = shifted[ACC_W-1:0];
            end
            quo_next = {quo_reg[DIV_W-2:0], ge};
        end

        if (cmd.eval) begin
            level_next       = clamp_level(lv_new);
            res_set_next     = 1'b1;
            res_load_next    = (quo_reg > DIV_W'(255)) ? 8'hFF : quo_reg[7:0];
            res_outcome_next = OUT_EVAL;
            tot_acc_next     = '0;
            busy_acc_next    = '0;
        end
    end

    assign result.level     = level_reg;
    assign result.level_set = res_set_reg;
    assign result.load_pct  = res_load_reg;
    assign result.outcome   = res_outcome_reg;

endmodule

// ===== hw/rtl/gllg_checker.sv =====
// Port-level checker of the load level governor and its bind to the top.
// Depends on gllg_pkg and gpu_load_level_governor.
module gllg_checker
    import gllg_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [55:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a beat was still in work");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != OUT_EVAL) |-> (m_tdata[11:4] == 8'd0))
        else $error("load reported without an evaluation");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == OUT_WAIT) |-> !m_tdata[3])
        else $error("level request issued while waiting");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == OUT_SLEEP) || (m_tuser == OUT_FORCE) ||
                     (m_tuser == OUT_EVAL)) |-> m_tdata[3])
        else $error("level request missing");

endmodule

bind gpu_load_level_governor gllg_checker u_checker (.*);
